@@ rtl/hbca_pkg.sv @@
// Package of types, constants and helpers shared by the buffer cache allocator.
package hbca_pkg;

  localparam int unsigned NumBuffers  = 32;
  localparam int unsigned NumBuckets  = 13;
  localparam int unsigned RefcountMax = 255;

  localparam int unsigned SlotW   = 5;
  localparam int unsigned BucketW = 4;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CountW  = 8;

  // Reciprocal of the bucket count, scaled by 2^36 and rounded up; exact for
  // every 32-bit block number.
  localparam logic [36:0] HashMagic =
    37'(((64'd1 << 36) + 64'(NumBuckets) - 64'd1) / 64'(NumBuckets));

  typedef enum logic [1:0] {
    CmdRead    = 2'd0,
    CmdRelease = 2'd1,
    CmdPin     = 2'd2,
    CmdUnpin   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoFree    = 3'd1,
    StUnderflow = 3'd2,
    StOverflow  = 3'd3,
    StBadSlot   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] device_id;
    logic [31:0] block_number;
    logic [4:0]  buffer_slot;
  } req_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic       tag_hit;
    logic       need_disk_read;
    logic [2:0] status;
    logic [7:0] count_after;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;     // capture request, reset scan
    logic       hash;     // finish the home bucket of the request
    logic       scan;     // examine one buffer at index
    logic       next_bkt; // advance the bucket ring
    logic       commit;   // apply the chosen action
    logic [1:0] mode;     // 0 tag, 1 free in home, 2 free in other bucket
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_idx;  // the scan is at the last buffer
    logic found;     // a candidate is held at the start of a pass
    logic ring_done; // ring returned to the home bucket
  } dp_sts_t;

  localparam logic [1:0] ModeTag   = 2'd0;
  localparam logic [1:0] ModeHome  = 2'd1;
  localparam logic [1:0] ModeOther = 2'd2;

  // Initial bucket of a buffer.
  function automatic logic [BucketW-1:0] init_bucket(input int unsigned i);
    return BucketW'(i % NumBuckets);
  endfunction

  // Initial list position: count of later buffers in the same bucket.
  function automatic logic [PosW-1:0] init_pos(input int unsigned i);
    int unsigned n;
    n = 0;
    for (int unsigned j = 0; j < NumBuffers; j++) begin
      if (j > i && (j % NumBuckets) == (i % NumBuckets)) n++;
    end
    return PosW'(n);
  endfunction

endpackage

@@ rtl/hashed_buffer_cache_allocator_unit.sv @@
// Top level of the hashed buffer cache allocator.
//
//  Channel   Direction  Handshake               Beat
//  in        input      in_valid_i/in_stall_o   hbca_pkg::req_t
//  out       output     out_valid_o/out_stall_i hbca_pkg::rsp_t
//
// Release, pin and unpin go from acceptance to commit and then to their result.
// A read first works out its home bucket, then makes one pass over the table for
// the tag, then one pass for a free buffer in its home bucket and one per further
// bucket; the single scan port over the buffer table walks these passes in turn,
// so a hit gives its result beat after the tag pass and a miss after the free passes.
// One item is in work at a time; in_stall_o stays high until its result has gone.
// Reset brings the table to its initial bucket lists at once; no sweep.
// The result register holds its beat while out_stall_i is high.
module hashed_buffer_cache_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hbca_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hbca_pkg::rsp_t out_data_o
);
  import hbca_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The controller sequences the scan passes; the datapath owns the buffer table.
  hbca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_is_read_i (in_data_i.cmd == CmdRead),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dp_cmd_o     (dp_cmd),
    .dp_sts_i     (dp_sts)
  );

  hbca_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (out_data_o)
  );

endmodule

@@ rtl/hbca_ctrl.sv @@
// Controller state machine for the buffer cache allocator.
module hbca_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_is_read_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hbca_pkg::dp_cmd_t dp_cmd_o,
  input  hbca_pkg::dp_sts_t dp_sts_i
);
  import hbca_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] STag   = 3'd1;
  localparam logic [2:0] SHome  = 3'd2;
  localparam logic [2:0] SOther = 3'd3;
  localparam logic [2:0] SComm  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;
  localparam logic [2:0] SHash  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign accept      = in_valid_i && (state_q == SIdle);

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          state_d = in_is_read_i ? SHash : SComm;
        end
      end
      SHash: begin
        dp_cmd_o.hash = 1'b1;
        state_d = STag;
      end
      STag: begin
        dp_cmd_o.scan = 1'b1;
        dp_cmd_o.mode = ModeTag;
        if (dp_sts_i.last_idx) state_d = SHome;
      end
      SHome: begin
        if (dp_sts_i.found) begin
          state_d = SComm;
        end else begin
          dp_cmd_o.scan = 1'b1;
          dp_cmd_o.mode = ModeHome;
          if (dp_sts_i.last_idx) state_d = SOther;
        end
      end
      SOther: begin
        if (dp_sts_i.found || dp_sts_i.ring_done) begin
          state_d = SComm;
        end else begin
          dp_cmd_o.scan     = 1'b1;
          dp_cmd_o.mode     = ModeOther;
          dp_cmd_o.next_bkt = dp_sts_i.last_idx;
        end
      end
      SComm: begin
        dp_cmd_o.commit = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // A load only ever happens on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.load |-> accept) else $error("load without accept");
  // Commit is followed by a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.commit |=> out_valid_o) else $error("commit without result");
  // Scan and commit never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd_o.scan && dp_cmd_o.commit)) else $error("scan and commit");

endmodule

@@ rtl/hbca_datapath.sv @@
// Datapath of the buffer cache allocator: buffer table, scan and update.
module hbca_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbca_pkg::req_t    req_i,
  input  hbca_pkg::dp_cmd_t cmd_i,
  output hbca_pkg::dp_sts_t sts_o,
  output hbca_pkg::rsp_t    rsp_o
);
  import hbca_pkg::*;

  logic [15:0]        dev_tag_q  [NumBuffers];
  logic [31:0]        blk_tag_q  [NumBuffers];
  logic [CountW-1:0]  cnt_q      [NumBuffers];
  logic               cvalid_q   [NumBuffers];
  logic [BucketW-1:0] bkt_q      [NumBuffers];
  logic [PosW-1:0]    pos_q      [NumBuffers];

  req_t               req_q;
  logic [BucketW-1:0] home_q, cur_bkt_q;
  logic [SlotW-1:0]   idx_q, best_q;
  logic [PosW-1:0]    best_pos_q;
  logic               found_q, hit_q, moved_q;
  rsp_t               rsp_q;
  logic [31:0]        quot_q;

  // Home bucket by reciprocal multiplication: the quotient is taken when the
  // request is loaded, the remainder in the following cycle.
  logic [68:0]        hash_prod_w;
  logic [31:0]        hash_rem_w;
  logic [BucketW-1:0] home_w;
  assign hash_prod_w = {37'd0, req_i.block_number} * {32'd0, HashMagic};
  assign hash_rem_w  = req_q.block_number - quot_q * 32'(NumBuckets);
  assign home_w      = BucketW'(hash_rem_w);

  logic cand;
  always_comb begin
    cand = 1'b0;
    if (cmd_i.mode == ModeTag) begin
      cand = bkt_q[idx_q] == home_q && dev_tag_q[idx_q] == req_q.device_id
             && blk_tag_q[idx_q] == req_q.block_number;
    end else if (cmd_i.mode == ModeHome) begin
      cand = bkt_q[idx_q] == home_q && cnt_q[idx_q] == '0;
    end else begin
      cand = bkt_q[idx_q] == cur_bkt_q && cnt_q[idx_q] == '0;
    end
  end

  logic [BucketW-1:0] nxt_bkt;
  assign nxt_bkt = (cur_bkt_q == BucketW'(NumBuckets - 1)) ? '0 : cur_bkt_q + 1'b1;

  // The front-most candidate is only known once a whole pass has been made.
  assign sts_o.last_idx  = idx_q == SlotW'(NumBuffers - 1);
  assign sts_o.found     = found_q && idx_q == '0;
  assign sts_o.ring_done = cur_bkt_q == home_q;
  assign rsp_o           = rsp_q;

  logic [SlotW-1:0]  s;
  logic [CountW-1:0] c;
  assign s = hit_q || found_q ? best_q : req_q.buffer_slot;
  assign c = cnt_q[s];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumBuffers; i++) begin
        dev_tag_q[i] <= '0;
        blk_tag_q[i] <= '0;
        cnt_q[i]     <= '0;
        cvalid_q[i]  <= 1'b0;
        bkt_q[i]     <= init_bucket(i);
        pos_q[i]     <= init_pos(i);
      end
      found_q <= 1'b0;
      hit_q   <= 1'b0;
      moved_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        req_q      <= req_i;
        quot_q     <= hash_prod_w[67:36];
        idx_q      <= '0;
        found_q    <= 1'b0;
        hit_q      <= 1'b0;
        moved_q    <= 1'b0;
      end
      if (cmd_i.hash) begin
        home_q     <= home_w;
        cur_bkt_q  <= (home_w == BucketW'(NumBuckets - 1)) ? '0 : home_w + 1'b1;
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
        if (cand && (!found_q || pos_q[idx_q] < best_pos_q)) begin
          found_q    <= 1'b1;
          best_q     <= idx_q;
          best_pos_q <= pos_q[idx_q];
        end
        if (sts_o.last_idx) begin
          idx_q <= '0;
          if (cmd_i.mode == ModeTag) hit_q <= found_q || cand;
          if (cmd_i.mode == ModeOther) moved_q <= 1'b1;
          if (cmd_i.next_bkt && !(found_q || cand)) cur_bkt_q <= nxt_bkt;
        end
      end
      if (cmd_i.commit) begin
        rsp_q <= '0;
        if (req_q.cmd == CmdRead) begin
          if (hit_q) begin
            if (c >= CountW'(RefcountMax)) begin
              cnt_q[s] <= CountW'(RefcountMax);
              rsp_q.status <= StOverflow;
              rsp_q.count_after <= CountW'(RefcountMax);
            end else begin
              cnt_q[s] <= c + 1'b1;
              rsp_q.count_after <= c + 1'b1;
            end
            rsp_q.slot_out <= s;
            rsp_q.tag_hit  <= 1'b1;
            rsp_q.need_disk_read <= !cvalid_q[s];
            cvalid_q[s] <= 1'b1;
          end else if (found_q) begin
            if (moved_q) begin
              for (int unsigned i = 0; i < NumBuffers; i++) begin
                if (SlotW'(i) != s) begin
                  if (bkt_q[i] == bkt_q[s] && pos_q[i] > pos_q[s])
                    pos_q[i] <= pos_q[i] - 1'b1;
                  if (bkt_q[i] == home_q) pos_q[i] <= pos_q[i] + 1'b1;
                end
              end
              bkt_q[s] <= home_q;
              pos_q[s] <= '0;
            end
            dev_tag_q[s] <= req_q.device_id;
            blk_tag_q[s] <= req_q.block_number;
            cnt_q[s]     <= CountW'(1);
            cvalid_q[s]  <= 1'b1;
            rsp_q.slot_out <= s;
            rsp_q.need_disk_read <= 1'b1;
            rsp_q.count_after <= CountW'(1);
          end else begin
            rsp_q.status <= StNoFree;
          end
        end else if (int'(req_q.buffer_slot) >= NumBuffers) begin
          rsp_q.slot_out <= req_q.buffer_slot;
          rsp_q.status   <= StBadSlot;
        end else if (req_q.cmd == CmdPin) begin
          rsp_q.slot_out <= s;
          if (c >= CountW'(RefcountMax)) begin
            cnt_q[s] <= CountW'(RefcountMax);
            rsp_q.status <= StOverflow;
            rsp_q.count_after <= CountW'(RefcountMax);
          end else begin
            cnt_q[s] <= c + 1'b1;
            rsp_q.count_after <= c + 1'b1;
          end
        end else begin
          rsp_q.slot_out <= s;
          if (c == '0) begin
            rsp_q.status <= StUnderflow;
          end else begin
            cnt_q[s] <= c - 1'b1;
            rsp_q.count_after <= c - 1'b1;
          end
        end
      end
    end
  end

  // A hit never leaves a candidate of the free scan behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && req_q.cmd == CmdRead && hit_q |-> !moved_q)
    else $error("hit with move");
  // Commit reports the home bucket for a moved buffer next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && req_q.cmd == CmdRead && found_q && !hit_q
    |=> bkt_q[$past(best_q)] == $past(home_q)) else $error("bucket not moved");
  // Counts never exceed the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> rsp_q.count_after <= CountW'(RefcountMax))
    else $error("count above maximum");

endmodule

@@ tb/tb_hashed_buffer_cache_allocator_unit.sv @@
// Self-checking testbench for the hashed buffer cache allocator.
module tb_hashed_buffer_cache_allocator_unit;
  import hbca_pkg::*;

  // A read may walk every bucket over the whole table; allow for that.
  localparam int unsigned ReadCycles = NumBuckets * NumBuffers + 64;
  localparam int unsigned CycleLimit = 900 * (ReadCycles + 200) * 4;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  req_t   in_data_i;
  logic   out_valid_o;
  logic   out_stall_i;
  rsp_t   out_data_o;

  hashed_buffer_cache_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Our own copy of the buffer table, updated as each beat is sent.
  logic [15:0]        mdl_dev    [NumBuffers];
  logic [31:0]        mdl_blk    [NumBuffers];
  int unsigned        mdl_count  [NumBuffers];
  logic               mdl_valid  [NumBuffers];
  int unsigned        mdl_bucket [NumBuffers];
  int unsigned        mdl_pos    [NumBuffers];

  rsp_t        pending_rsp[$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_sent;
  int unsigned n_hits;
  int unsigned n_nofree;
  int unsigned n_overflow;
  bit          quiet_out;
  int unsigned cycle_count = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void table_reset();
    for (int i = 0; i < NumBuffers; i++) begin
      mdl_dev[i]    = '0;
      mdl_blk[i]    = '0;
      mdl_count[i]  = 0;
      mdl_valid[i]  = 1'b0;
      mdl_bucket[i] = i % NumBuckets;
    end
    for (int i = 0; i < NumBuffers; i++) begin
      mdl_pos[i] = 0;
      for (int j = i + 1; j < NumBuffers; j++) begin
        if (mdl_bucket[j] == mdl_bucket[i]) mdl_pos[i]++;
      end
    end
  endfunction

  // Front-most buffer of a bucket that matches the tag, or is free.
  function automatic int bucket_search(int unsigned bk, bit want_tag,
                                       logic [15:0] dev, logic [31:0] blk);
    int best;
    int unsigned best_pos;
    bit ok;
    best = -1;
    best_pos = 0;
    for (int i = 0; i < NumBuffers; i++) begin
      if (mdl_bucket[i] != bk) continue;
      ok = want_tag ? (mdl_dev[i] == dev && mdl_blk[i] == blk) : (mdl_count[i] == 0);
      if (ok && (best < 0 || mdl_pos[i] < best_pos)) begin
        best = i;
        best_pos = mdl_pos[i];
      end
    end
    return best;
  endfunction

  function automatic void steal_to_home(int b, int unsigned home);
    int unsigned old_bk;
    int unsigned old_pos;
    old_bk = mdl_bucket[b];
    old_pos = mdl_pos[b];
    for (int i = 0; i < NumBuffers; i++) begin
      if (i == b) continue;
      if (mdl_bucket[i] == old_bk && mdl_pos[i] > old_pos) mdl_pos[i]--;
      if (mdl_bucket[i] == home) mdl_pos[i]++;
    end
    mdl_bucket[b] = home;
    mdl_pos[b] = 0;
  endfunction

  // Works out the response to one request and advances the table.
  function automatic rsp_t cache_response(req_t rq);
    rsp_t r;
    int unsigned home;
    int unsigned k;
    int b;
    r = '0;
    if (rq.cmd == CmdRead) begin
      home = rq.block_number % NumBuckets;
      b = bucket_search(home, 1'b1, rq.device_id, rq.block_number);
      if (b >= 0) begin
        n_hits++;
        r.status = StOk;
        if (mdl_count[b] >= RefcountMax) begin
          mdl_count[b] = RefcountMax;
          r.status = StOverflow;
          n_overflow++;
        end else begin
          mdl_count[b]++;
        end
        r.slot_out = b[4:0];
        r.tag_hit = 1'b1;
        r.need_disk_read = !mdl_valid[b];
        mdl_valid[b] = 1'b1;
        r.count_after = mdl_count[b][7:0];
        return r;
      end
      b = bucket_search(home, 1'b0, '0, '0);
      if (b < 0) begin
        k = home;
        for (int n = 1; n < NumBuckets; n++) begin
          k = (k + 1) % NumBuckets;
          b = bucket_search(k, 1'b0, '0, '0);
          if (b >= 0) begin
            steal_to_home(b, home);
            break;
          end
        end
      end
      if (b < 0) begin
        n_nofree++;
        r.status = StNoFree;
        return r;
      end
      mdl_dev[b] = rq.device_id;
      mdl_blk[b] = rq.block_number;
      mdl_count[b] = 1;
      mdl_valid[b] = 1'b1;
      r.slot_out = b[4:0];
      r.need_disk_read = 1'b1;
      r.status = StOk;
      r.count_after = 8'd1;
      return r;
    end
    r.slot_out = rq.buffer_slot;
    if (rq.buffer_slot >= NumBuffers) begin
      r.status = StBadSlot;
      return r;
    end
    if (rq.cmd == CmdPin) begin
      r.status = StOk;
      if (mdl_count[rq.buffer_slot] >= RefcountMax) begin
        mdl_count[rq.buffer_slot] = RefcountMax;
        r.status = StOverflow;
        n_overflow++;
      end else begin
        mdl_count[rq.buffer_slot]++;
      end
      r.count_after = mdl_count[rq.buffer_slot][7:0];
      return r;
    end
    if (mdl_count[rq.buffer_slot] == 0) begin
      r.status = StUnderflow;
      return r;
    end
    mdl_count[rq.buffer_slot]--;
    r.status = StOk;
    r.count_after = mdl_count[rq.buffer_slot][7:0];
    return r;
  endfunction

  // Sends one beat, idling first at random, and holds it until accepted.
  // The block stalls after each accepted beat until its result has gone, so
  // dropping valid after acceptance costs no throughput.
  task automatic send_beat(req_t rq, bit may_idle);
    while (may_idle && $urandom_range(99) < 22) begin
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    pending_rsp.push_back(cache_response(rq));
    n_sent++;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t make_req(cmd_e c, logic [15:0] dev, logic [31:0] blk,
                                    logic [4:0] slot);
    req_t rq;
    rq.cmd = c;
    rq.device_id = dev;
    rq.block_number = blk;
    rq.buffer_slot = slot;
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall, and every accepted beat compared field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: response with none pending: %p", $time, out_data_o);
          n_errors++;
        end else begin
          exp_rsp = pending_rsp.pop_front();
          n_checked++;
          if (out_data_o.slot_out !== exp_rsp.slot_out) begin
            $display("%0t: slot_out expected %0d actual %0d", $time,
                     exp_rsp.slot_out, out_data_o.slot_out);
            n_errors++;
          end
          if (out_data_o.tag_hit !== exp_rsp.tag_hit) begin
            $display("%0t: tag_hit expected %0b actual %0b", $time,
                     exp_rsp.tag_hit, out_data_o.tag_hit);
            n_errors++;
          end
          if (out_data_o.need_disk_read !== exp_rsp.need_disk_read) begin
            $display("%0t: need_disk_read expected %0b actual %0b", $time,
                     exp_rsp.need_disk_read, out_data_o.need_disk_read);
            n_errors++;
          end
          if (out_data_o.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, out_data_o.status);
            n_errors++;
          end
          if (out_data_o.count_after !== exp_rsp.count_after) begin
            $display("%0t: count_after expected %0d actual %0d", $time,
                     exp_rsp.count_after, out_data_o.count_after);
            n_errors++;
          end
        end
      end
      out_stall_i <= !quiet_out && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Extremes of the fields, every command, and the named corner cases.
  task automatic test_directed();
    send_beat(make_req(CmdRead, 16'h0000, 32'h0, 5'd0), 1'b1);  // hits a reset buffer
    send_beat(make_req(CmdRead, 16'hFFFF, 32'hFFFF_FFFF, 5'd31), 1'b1);
    send_beat(make_req(CmdRead, 16'hFFFF, 32'hFFFF_FFFF, 5'd0), 1'b1);
    send_beat(make_req(CmdRelease, 16'h0, 32'h0, 5'd31), 1'b1);
    send_beat(make_req(CmdUnpin, 16'hFFFF, 32'h0, 5'd5), 1'b1);  // underflow
    send_beat(make_req(CmdPin, 16'h0, 32'hFFFF_FFFF, 5'd0), 1'b1);
    send_beat(make_req(CmdUnpin, 16'h0, 32'h0, 5'd0), 1'b1);
    send_beat(make_req(CmdRelease, 16'h0, 32'h0, 5'd0), 1'b1);
    send_beat(make_req(CmdRelease, 16'h0, 32'h0, 5'd0), 1'b1);
    // Every block in one bucket forces stealing from the other buckets.
    for (int i = 0; i < 8; i++)
      send_beat(make_req(CmdRead, 16'h0012, 32'(i * NumBuckets + 7), 5'd0), 1'b1);
  endtask

  // Pins one buffer past the ceiling of its count, then brings it back.
  task automatic test_count_saturation();
    for (int i = 0; i < RefcountMax + 2; i++)
      send_beat(make_req(CmdPin, 16'h0, 32'h0, 5'd3), i > 240);
    send_beat(make_req(CmdRead, mdl_dev[3], mdl_blk[3], 5'd0), 1'b1);
    for (int i = 0; i < RefcountMax + 1; i++)
      send_beat(make_req(CmdUnpin, 16'h0, 32'h0, 5'd3), i > 240);
  endtask

  // Takes every buffer so that a further miss finds no free buffer.
  task automatic test_exhaustion();
    for (int i = 0; i < NumBuffers; i++)
      send_beat(make_req(CmdPin, 16'h0, 32'h0, i[4:0]), 1'b1);
    send_beat(make_req(CmdRead, 16'hBEEF, 32'h1234_5678, 5'd0), 1'b1);
    send_beat(make_req(CmdRead, 16'hBEEF, 32'h1234_5679, 5'd0), 1'b1);
    // The sender holds off until the pipe is empty.
    wait_drained();
    for (int i = 0; i < NumBuffers; i++)
      send_beat(make_req(CmdRelease, 16'h0, 32'h0, i[4:0]), 1'b1);
  endtask

  // Reads most often, over a small working set, so hits, steals and reuse all occur.
  task automatic test_random_traffic(int unsigned n_items, bit allow_idle);
    req_t rq;
    int unsigned pick;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      rq.device_id = 16'($urandom_range(3));
      rq.block_number = 32'($urandom_range(40));
      rq.buffer_slot = 5'($urandom_range(NumBuffers - 1));
      if ($urandom_range(15) == 0) begin
        rq.device_id = 16'($urandom);
        rq.block_number = $urandom;
        rq.buffer_slot = 5'($urandom);
      end
      if (pick < 45) rq.cmd = CmdRead;
      else if (pick < 75) rq.cmd = CmdRelease;
      else if (pick < 85) rq.cmd = CmdPin;
      else rq.cmd = CmdUnpin;
      send_beat(rq, allow_idle);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    n_sent      = 0;
    n_hits      = 0;
    n_nofree    = 0;
    n_overflow  = 0;
    quiet_out   = 1'b0;
    table_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_saturation();
    test_exhaustion();
    test_random_traffic(120, 1'b1);
    // A stretch with no idling on either side.
    quiet_out = 1'b1;
    test_random_traffic(60, 1'b0);
    quiet_out = 1'b0;
    test_random_traffic(70, 1'b1);

    wait_drained();
    repeat (ReadCycles) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d responses: %0d hits, %0d no-free, %0d saturations",
             n_sent, n_checked, n_hits, n_nofree, n_overflow);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
